// ===== design/smbus_slave_write_receiver_assert.svh =====
// assertion macros shared by the receiver rtl
// depends on clk_i and rst_ni being visible in the including module
`ifndef SMBUS_SLAVE_WRITE_RECEIVER_ASSERT_SVH
`define SMBUS_SLAVE_WRITE_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
`define SMBWR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SMBWR_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SMBWR_ASSERT(label, prop, msg)
`define SMBWR_NEVER(label, expr, msg)
`endif

`endif

// ===== design/smbwr_pkg.sv =====
// types and constants for the smbus slave write receiver
// no dependencies
package smbwr_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_SHIFT = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    PH_CHECK_ADDR = 3'd0,
    PH_PREP_CMD   = 3'd1,
    PH_READ_CMD   = 3'd2,
    PH_PREP_DATA  = 3'd3,
    PH_READ_DATA  = 3'd4,
    PH_DONE       = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_ACK     = 3'd1,
    ACT_NACK    = 3'd2,
    ACT_RECEIVE = 3'd3,
    ACT_STOP    = 3'd4
  } action_e;

  localparam int unsigned AddrW = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_OWN_ADDR = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CMD_CODE = 1'b1;

  localparam logic [AddrW-1:0] OWN_ADDR_RST = 7'h00;
  localparam logic [ByteW-1:0] CMD_CODE_RST = 8'h10;
  localparam logic [1:0]       DATA_BYTES   = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ByteW-1:0] rx_byte;
    logic             sda_low;
  } event_t;

  typedef struct packed {
    action_e          action;
    logic             message_valid;
    logic [ByteW-1:0] message_address;
    logic [ByteW-1:0] message_code;
  } result_t;

endpackage

// ===== design/smbwr_if.sv =====
// valid/ready channel interfaces for event and result beats
// depends on smbwr_pkg
interface smbwr_in_if;
  import smbwr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [ByteW-1:0] rx_byte;
  logic             sda_low;

  modport source (output valid, mode, rx_byte, sda_low, input ready);
  modport sink   (input valid, mode, rx_byte, sda_low, output ready);
endinterface

interface smbwr_out_if;
  import smbwr_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic             message_valid;
  logic [ByteW-1:0] message_address;
  logic [ByteW-1:0] message_code;

  modport source (output valid, action, message_valid, message_address, message_code,
                  input ready);
  modport sink   (input valid, action, message_valid, message_address, message_code,
                  output ready);
endinterface

// ===== design/smbwr_core.sv =====
// protocol state and per-event decision logic of the receiver
// depends on smbwr_pkg
module smbwr_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       evt_accept_i,
  input  smbwr_pkg::event_t          evt_i,
  input  logic [smbwr_pkg::AddrW-1:0] own_addr_i,
  input  logic [smbwr_pkg::ByteW-1:0] cmd_code_i,
  output smbwr_pkg::result_t         res_o
);
  import smbwr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] data_word_q, data_word_d;
  logic [1:0]  byte_count_q, byte_count_d;
  logic        msg_ready_q, msg_ready_d;
  logic [1:0]  count_inc;

  assign count_inc = byte_count_q + 2'd1;

  always_comb begin
    phase_d      = phase_q;
    data_word_d  = data_word_q;
    byte_count_d = byte_count_q;
    msg_ready_d  = msg_ready_q;
    res_o        = '0;
    res_o.action = ACT_NONE;
    unique case (mode_e'(evt_i.mode))
      MODE_START: begin
        if (evt_i.sda_low) begin
          phase_d      = PH_CHECK_ADDR;
          byte_count_d = 2'd0;
          res_o.action = ACT_RECEIVE;
        end
      end
      MODE_SHIFT: begin
        unique case (phase_q)
          PH_CHECK_ADDR: begin
            if (evt_i.rx_byte[ByteW-1:1] == own_addr_i) begin
              res_o.action = ACT_ACK;
              phase_d      = PH_PREP_CMD;
            end else begin
              res_o.action = ACT_STOP;
              phase_d      = PH_DONE;
            end
          end
          PH_PREP_CMD: begin
            res_o.action = ACT_RECEIVE;
            phase_d      = PH_READ_CMD;
          end
          PH_READ_CMD: begin
            if (!msg_ready_q && evt_i.rx_byte == cmd_code_i) begin
              res_o.action = ACT_ACK;
              phase_d      = PH_PREP_DATA;
            end else begin
              res_o.action = ACT_NACK;
              phase_d      = PH_DONE;
            end
          end
          PH_PREP_DATA: begin
            res_o.action = ACT_RECEIVE;
            phase_d      = PH_READ_DATA;
          end
          PH_READ_DATA: begin
            data_word_d  = {evt_i.rx_byte, data_word_q[15:8]};
            byte_count_d = count_inc;
            res_o.action = ACT_ACK;
            if (count_inc == DATA_BYTES) begin
              msg_ready_d = 1'b1;
              phase_d     = PH_DONE;
            end else begin
              phase_d     = PH_PREP_DATA;
            end
          end
          default: res_o.action = ACT_STOP;
        endcase
      end
      MODE_READ: begin
        if (msg_ready_q) begin
          res_o.message_valid   = 1'b1;
          res_o.message_address = data_word_q[15:8];
          res_o.message_code    = data_word_q[7:0];
        end
        msg_ready_d = 1'b0;
      end
      default: res_o.action = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DONE;
      data_word_q  <= '0;
      byte_count_q <= '0;
      msg_ready_q  <= 1'b0;
    end else if (evt_accept_i) begin
      phase_q      <= phase_d;
      data_word_q  <= data_word_d;
      byte_count_q <= byte_count_d;
      msg_ready_q  <= msg_ready_d;
    end
  end

endmodule

// ===== design/smbus_slave_write_receiver.sv =====
// channel   | dir | beat contents
// in_i      | in  | mode, rx_byte, sda_low
// out_o     | out | action, message_valid, message_address, message_code
// cfg       | in  | cfg_we_i, cfg_idx_i (0 own address, 1 command code), cfg_data_i
// one event beat per cycle; its result is in the output register the next cycle
// the output register decouples the sides: a new beat enters while a result is taken
// in_i.ready drops only while a result waits and out_o.ready is low
// reset (async, active low) leaves phase done, no message pending, registers at defaults
// depends on smbwr_pkg, smbwr_if, smbwr_core and the assertion macro header
`include "smbus_slave_write_receiver_assert.svh"

module smbus_slave_write_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  smbwr_in_if.sink                      in_i,
  smbwr_out_if.source                   out_o,
  input  logic                          cfg_we_i,
  input  logic [smbwr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [smbwr_pkg::ByteW-1:0]   cfg_data_i
);
  import smbwr_pkg::*;

  logic [AddrW-1:0] own_addr_q;
  logic [ByteW-1:0] cmd_code_q;
  logic             out_valid_q;
  result_t          out_res_q;
  result_t          res;
  event_t           evt;
  logic             in_ready;
  logic             in_accept;

  assign in_ready  = !out_valid_q || out_o.ready;
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign evt.mode    = in_i.mode;
  assign evt.rx_byte = in_i.rx_byte;
  assign evt.sda_low = in_i.sda_low;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OWN_ADDR_RST;
      cmd_code_q <= CMD_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OWN_ADDR: own_addr_q <= cfg_data_i[AddrW-1:0];
        CFG_CMD_CODE: cmd_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  smbwr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_accept_i (in_accept),
    .evt_i        (evt),
    .own_addr_i   (own_addr_q),
    .cmd_code_i   (cmd_code_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.action          = out_res_q.action;
  assign out_o.message_valid   = out_res_q.message_valid;
  assign out_o.message_address = out_res_q.message_address;
  assign out_o.message_code    = out_res_q.message_code;

  // accepted event always yields a result beat next cycle
  `SMBWR_ASSERT(a_accept_gives_result, in_accept |=> out_valid_q, "event beat lost")
  // a waiting result is never overwritten
  `SMBWR_NEVER(a_no_overwrite, in_accept && out_valid_q && !out_o.ready, "result overwritten")
  // a delivered message carries no action, as it only comes from a read request
  `SMBWR_ASSERT(a_msg_no_action,
                out_valid_q && out_res_q.message_valid |-> out_res_q.action == ACT_NONE,
                "message with action")

endmodule

// ===== sim/tb_smbus_slave_write_receiver.sv =====
`timescale 1ns / 100ps
// self-checking testbench for smbus_slave_write_receiver: directed table, then random bus traffic
// depends on smbwr_pkg, smbwr_if and the receiver rtl
module tb_smbus_slave_write_receiver;
  import smbwr_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned HoldOffAt = 300;
  localparam int unsigned HoldOffCycles = 64;

  typedef struct {
    event_t  ev;
    bit      typed;
    result_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [ByteW-1:0] cfg_data;

  smbwr_in_if  in_ch ();
  smbwr_out_if out_ch ();

  smbus_slave_write_receiver dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [AddrW-1:0] own_addr_q;
  logic [ByteW-1:0] cmd_code_q;
  phase_e           bus_phase;
  logic [15:0]      word_q;
  logic [1:0]       byte_cnt;
  logic             msg_ready;

  result_t     pending_results[$];
  bit          row_typed;
  result_t     row_result;
  int unsigned errors;
  int unsigned beats_in;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned stall_cycles;
  int unsigned acks, nacks, receives, stops, messages;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("smbus_slave_write_receiver regression: fail");
    $finish;
  end

  function automatic result_t bus_response(input event_t ev);
    result_t r;
    r = '0;
    r.action = ACT_NONE;
    case (ev.mode)
      MODE_START: begin
        if (ev.sda_low) begin
          bus_phase = PH_CHECK_ADDR;
          byte_cnt  = '0;
          r.action  = ACT_RECEIVE;
        end
      end
      MODE_SHIFT: begin
        case (bus_phase)
          PH_CHECK_ADDR: begin
            if (ev.rx_byte[7:1] == own_addr_q) begin
              r.action  = ACT_ACK;
              bus_phase = PH_PREP_CMD;
            end else begin
              r.action  = ACT_STOP;
              bus_phase = PH_DONE;
            end
          end
          PH_PREP_CMD: begin
            r.action  = ACT_RECEIVE;
            bus_phase = PH_READ_CMD;
          end
          PH_READ_CMD: begin
            if (!msg_ready && ev.rx_byte == cmd_code_q) begin
              r.action  = ACT_ACK;
              bus_phase = PH_PREP_DATA;
            end else begin
              r.action  = ACT_NACK;
              bus_phase = PH_DONE;
            end
          end
          PH_PREP_DATA: begin
            r.action  = ACT_RECEIVE;
            bus_phase = PH_READ_DATA;
          end
          PH_READ_DATA: begin
            word_q   = {ev.rx_byte, word_q[15:8]};
            byte_cnt = byte_cnt + 2'd1;
            r.action = ACT_ACK;
            if (byte_cnt == DATA_BYTES) begin
              msg_ready = 1'b1;
              bus_phase = PH_DONE;
            end else begin
              bus_phase = PH_PREP_DATA;
            end
          end
          default: r.action = ACT_STOP;
        endcase
      end
      MODE_READ: begin
        if (msg_ready) begin
          r.message_valid   = 1'b1;
          r.message_address = word_q[15:8];
          r.message_code    = word_q[7:0];
        end
        msg_ready = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic event_t mk_event(logic [1:0] m, logic [7:0] rx, logic sda);
    event_t e;
    e.mode    = m;
    e.rx_byte = rx;
    e.sda_low = sda;
    return e;
  endfunction

  function automatic row_t mk_row(logic [1:0] m, logic [7:0] rx, logic sda, bit typed,
                                  action_e act, logic v, logic [7:0] a, logic [7:0] c);
    row_t row;
    row.ev                  = mk_event(m, rx, sda);
    row.typed               = typed;
    row.res.action          = act;
    row.res.message_valid   = v;
    row.res.message_address = a;
    row.res.message_code    = c;
    return row;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    if (errors <= 30) begin
      $display("result %0d: %s got 0x%0h, expected 0x%0h", results_seen, field, got, want);
    end
  endtask

  // result and event monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (in_ch.valid && !in_ch.ready) stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("beat with no pending event, action", 16'(out_ch.action), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.action !== want.action)
            report_mismatch("action", 16'(out_ch.action), 16'(want.action));
          if (out_ch.message_valid !== want.message_valid)
            report_mismatch("message_valid", 16'(out_ch.message_valid),
                            16'(want.message_valid));
          if (out_ch.message_address !== want.message_address)
            report_mismatch("message_address", 16'(out_ch.message_address),
                            16'(want.message_address));
          if (out_ch.message_code !== want.message_code)
            report_mismatch("message_code", 16'(out_ch.message_code),
                            16'(want.message_code));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        beats_in++;
        want = bus_response(mk_event(in_ch.mode, in_ch.rx_byte, in_ch.sda_low));
        case (want.action)
          ACT_ACK:     acks++;
          ACT_NACK:    nacks++;
          ACT_RECEIVE: receives++;
          ACT_STOP:    stops++;
          default: ;
        endcase
        if (want.message_valid) messages++;
        if (row_typed) want = row_result;
        pending_results.push_back(want);
      end
    end
  end

  // result side stalls, with one long hold-off to back up the input
  initial begin
    int unsigned stall_pct;
    int unsigned hold_left;
    bit          held;
    stall_pct = 0;
    hold_left = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 49) == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      if (!held && beats_in >= HoldOffAt) begin
        held      = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_event(input event_t ev, input bit typed, input result_t res);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= ev.mode;
    in_ch.rx_byte <= ev.rx_byte;
    in_ch.sda_low <= ev.sda_low;
    row_typed     <= typed;
    row_result    <= res;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_plain(input event_t ev);
    send_event(ev, 1'b0, '0);
  endtask

  // start, address, command and two data bytes, sometimes cut short
  task automatic send_write_sequence();
    event_t      seq[$];
    int unsigned count;
    seq.push_back(mk_event(MODE_START, rand_byte(), 1'b1));
    if ($urandom_range(0, 99) < 85)
      seq.push_back(mk_event(MODE_SHIFT, {own_addr_q, rand_bit()}, rand_bit()));
    else
      seq.push_back(mk_event(MODE_SHIFT, rand_byte(), rand_bit()));
    seq.push_back(mk_event(MODE_SHIFT, rand_byte(), rand_bit()));
    if ($urandom_range(0, 99) < 80)
      seq.push_back(mk_event(MODE_SHIFT, cmd_code_q, rand_bit()));
    else
      seq.push_back(mk_event(MODE_SHIFT, rand_byte(), rand_bit()));
    repeat (4) seq.push_back(mk_event(MODE_SHIFT, rand_byte(), rand_bit()));
    count = ($urandom_range(0, 99) < 15) ? $urandom_range(2, 8) : seq.size();
    for (int i = 0; i < count; i++) send_plain(seq[i]);
    if ($urandom_range(0, 9) == 0)
      send_plain(mk_event(MODE_SHIFT, rand_byte(), rand_bit()));
    if ($urandom_range(0, 99) < 60)
      send_plain(mk_event(MODE_READ, rand_byte(), rand_bit()));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [ByteW-1:0] addr_raw, input logic [ByteW-1:0] cmd);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_OWN_ADDR;
    cfg_data <= addr_raw;
    @(posedge clk_i);
    cfg_idx  <= CFG_CMD_CODE;
    cfg_data <= cmd;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    own_addr_q = addr_raw[AddrW-1:0];
    cmd_code_q = cmd;
  endtask

  initial begin
    row_t        rows[$];
    int unsigned phase_base;
    int unsigned pick;
    logic [7:0]  addr_raw;
    logic [7:0]  cmd;

    errors = 0; beats_in = 0; results_seen = 0; items_sent = 0; burst_left = 0;
    stall_cycles = 0; acks = 0; nacks = 0; receives = 0; stops = 0; messages = 0;
    own_addr_q = OWN_ADDR_RST;
    cmd_code_q = CMD_CODE_RST;
    bus_phase  = PH_DONE;
    word_q     = '0;
    byte_cnt   = '0;
    msg_ready  = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_OWN_ADDR;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_START;
    in_ch.rx_byte <= '0;
    in_ch.sda_low <= 1'b0;
    row_typed     <= 1'b0;
    row_result    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings: address 0, command 0x10
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 1, ACT_STOP,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_READ,    8'h00, 1'b0, 1, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_START,   8'hFF, 1'b0, 1, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_IGNORED, 8'hFF, 1'b1, 1, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_START,   8'h00, 1'b1, 1, ACT_RECEIVE, 0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h01, 1'b0, 1, ACT_ACK,     0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'hFF, 1'b1, 1, ACT_RECEIVE, 0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h10, 1'b0, 1, ACT_ACK,     0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 0, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'hFF, 1'b0, 0, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 0, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 0, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h55, 1'b0, 1, ACT_STOP,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_START,   8'h00, 1'b1, 1, ACT_RECEIVE, 0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 1, ACT_ACK,     0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 0, ACT_NONE,    0, 8'h00, 8'h00));
    // command refused while a message is pending
    rows.push_back(mk_row(MODE_SHIFT,   8'h10, 1'b0, 1, ACT_NACK,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_READ,    8'h00, 1'b0, 1, ACT_NONE,    1, 8'h00, 8'hFF));
    rows.push_back(mk_row(MODE_READ,    8'hFF, 1'b1, 1, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_START,   8'h00, 1'b1, 1, ACT_RECEIVE, 0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'hFE, 1'b0, 1, ACT_STOP,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_START,   8'h00, 1'b1, 0, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 0, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h00, 1'b0, 0, ACT_NONE,    0, 8'h00, 8'h00));
    rows.push_back(mk_row(MODE_SHIFT,   8'h11, 1'b0, 1, ACT_NACK,    0, 8'h00, 8'h00));
    foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].res);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin addr_raw = 8'hFF; cmd = 8'hFF; end
        1: begin addr_raw = 8'h00; cmd = 8'h00; end
        default: begin addr_raw = rand_byte(); cmd = rand_byte(); end
      endcase
      apply_settings(addr_raw, cmd);
      phase_base = items_sent;
      while (items_sent - phase_base < ItemsPerPhase) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_write_sequence();
        else if (pick < 75)
          send_plain(mk_event(MODE_READ, rand_byte(), rand_bit()));
        else if (pick < 85)
          send_plain(mk_event(MODE_START, rand_byte(), rand_bit()));
        else
          send_plain(mk_event(2'($urandom_range(0, 3)), rand_byte(), rand_bit()));
      end
      settle();
    end

    if (pending_results.size() != 0)
      report_mismatch("events left without a result", 16'(pending_results.size()), '0);
    $display("covered %0d event beats over %0d settings, %0d messages read back",
             beats_in, NumPhases + 1, messages);
    $display("ack %0d, nack %0d, receive %0d, stop %0d, input stalled %0d cycles",
             acks, nacks, receives, stops, stall_cycles);
    if (errors == 0) begin
      $display("smbus_slave_write_receiver regression: pass");
    end else begin
      $display("smbus_slave_write_receiver regression: fail");
    end
    $finish;
  end

endmodule
